### sv/rpe_pkg.sv
// rpe_pkg: sizes, codes and controller/datapath types of the range partition engine
// no dependencies; imported by rpe_if, rpe_ctrl, rpe_dp and the top level
package rpe_pkg;

    // store size and derived widths
    localparam int DEPTH     = 64;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int VALUE_W   = 32;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = CFG_IDX_W'(1);

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_I_RD,
        ST_I_CHK,
        ST_J_RD,
        ST_J_CHK,
        ST_SWAP,
        ST_E_RD,
        ST_E_LD
    } state_t;

    // store read address source
    typedef enum logic [1:0] {
        RD_I,
        RD_J,
        RD_K
    } rd_sel_t;

    // store write during partition
    typedef enum logic [1:0] {
        WR_NONE,
        WR_SWAP_I,
        WR_SWAP_J
    } wr_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic    ld_item;
        logic    clr_ptr;
        logic    inc_i;
        logic    set_j;
        logic    inc_j;
        logic    cap_vi;
        logic    inc_k;
        logic    load_out;
        logic    end_set;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic i_done;
        logic j_done;
        logic in_range;
        logic out_free;
        logic k_last;
    } dp_sts_t;

endpackage

### sv/rpe_if.sv
// rpe_if: valid/ready channel interfaces for items, results and configuration writes
// depends on rpe_pkg for field widths

// input items
interface rpe_item_if import rpe_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] item_value;
    logic                      item_last;

    modport source (output valid, item_value, item_last, input ready);
    modport sink   (input valid, item_value, item_last, output ready);
endinterface

// result items
interface rpe_result_if import rpe_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    logic                      out_last;
    logic                      out_dropped;

    modport source (output valid, out_value, out_last, out_dropped, input ready);
    modport sink   (input valid, out_value, out_last, out_dropped, output ready);
endinterface

// configuration register writes
interface rpe_cfg_if import rpe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VALUE_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/rpe_ram.sv
// rpe_ram: generic single write port, single read port memory with registered read
// no dependencies
module rpe_ram #(
    parameter int WIDTH  = 32,
    parameter int WORDS  = 64,
    parameter int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### sv/rpe_ctrl.sv
// rpe_ctrl: sequencer for load, in-place partition and emission of a set
// depends on rpe_pkg for state, command and status types
module rpe_ctrl import rpe_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  logic      item_last,
    output logic      item_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        item_ready   = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = RD_I;
        cmd.wr_sel   = WR_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.ld_item = 1'b1;
                    if (item_last)
                    begin
                        cmd.clr_ptr = 1'b1;
                        state_next  = ST_I_RD;
                    end
                end
            end
            // fetch the element at position i
            ST_I_RD:
            begin
                if (sts.i_done)
                begin
                    state_next = ST_E_RD;
                end
                else
                begin
                    cmd.rd_sel = RD_I;
                    state_next = ST_I_CHK;
                end
            end
            ST_I_CHK:
            begin
                cmd.cap_vi = 1'b1;
                if (sts.in_range)
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = ST_I_RD;
                end
                else
                begin
                    cmd.set_j  = 1'b1;
                    state_next = ST_J_RD;
                end
            end
            // search for the first in-range element after i
            ST_J_RD:
            begin
                if (sts.j_done)
                begin
                    // nothing in range past i, so no later swap can happen
                    state_next = ST_E_RD;
                end
                else
                begin
                    cmd.rd_sel = RD_J;
                    state_next = ST_J_CHK;
                end
            end
            ST_J_CHK:
            begin
                if (sts.in_range)
                begin
                    cmd.wr_sel = WR_SWAP_I;
                    state_next = ST_SWAP;
                end
                else
                begin
                    cmd.inc_j  = 1'b1;
                    state_next = ST_J_RD;
                end
            end
            ST_SWAP:
            begin
                cmd.wr_sel = WR_SWAP_J;
                cmd.inc_i  = 1'b1;
                state_next = ST_I_RD;
            end
            // emission, one read per free output slot
            ST_E_RD:
            begin
                if (sts.out_free)
                begin
                    cmd.rd_sel = RD_K;
                    state_next = ST_E_LD;
                end
            end
            ST_E_LD:
            begin
                cmd.load_out = 1'b1;
                cmd.inc_k    = 1'b1;
                if (sts.k_last)
                begin
                    cmd.end_set = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_E_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/rpe_dp.sv
// rpe_dp: element store, pointers, range compare, bound registers and output register
// depends on rpe_pkg and rpe_ram
module rpe_dp import rpe_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_cmd_t                 cmd,
    output dp_sts_t                   sts,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic                      cfg_valid,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [VALUE_W-1:0]        cfg_data,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      out_last,
    output logic                      out_dropped
);

    logic signed [VALUE_W-1:0] lower_reg;
    logic signed [VALUE_W-1:0] upper_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      overflow_reg;
    logic [CNT_W-1:0]          i_reg;
    logic [CNT_W-1:0]          j_reg;
    logic [CNT_W-1:0]          k_reg;
    logic signed [VALUE_W-1:0] vi_reg;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_last_reg;
    logic                      out_dropped_reg;

    logic                      full;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [VALUE_W-1:0]        mem_wdata;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [VALUE_W-1:0]        mem_rdata;
    logic signed [VALUE_W-1:0] rd_value;

    assign full     = (count_reg >= CNT_W'(DEPTH));
    assign rd_value = $signed(mem_rdata);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOWER: lower_reg <= $signed(cfg_data);
                CFG_UPPER: upper_reg <= $signed(cfg_data);
                default:   ;
            endcase
        end
    end

    // fill count and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.end_set)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.ld_item)
        begin
            if (full)
            begin
                overflow_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // partition and emission pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
        end
        else
        begin
            if (cmd.clr_ptr)
            begin
                i_reg <= '0;
                k_reg <= '0;
            end
            else
            begin
                if (cmd.inc_i)
                begin
                    i_reg <= i_reg + CNT_W'(1);
                end
                if (cmd.inc_k)
                begin
                    k_reg <= k_reg + CNT_W'(1);
                end
            end
            if (cmd.set_j)
            begin
                j_reg <= i_reg + CNT_W'(1);
            end
            else if (cmd.inc_j)
            begin
                j_reg <= j_reg + CNT_W'(1);
            end
        end
    end

    // held copy of the out-of-range element at i
    always_ff @(posedge clk)
    begin
        if (cmd.cap_vi)
        begin
            vi_reg <= rd_value;
        end
    end

    // store write port: load appends, swap writes i then j
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[ADDR_W-1:0];
        mem_wdata = item_value;
        priority if (cmd.ld_item)
        begin
            mem_we = !full;
        end
        else if (cmd.wr_sel == WR_SWAP_I)
        begin
            mem_we    = 1'b1;
            mem_waddr = i_reg[ADDR_W-1:0];
            mem_wdata = mem_rdata;
        end
        else if (cmd.wr_sel == WR_SWAP_J)
        begin
            mem_we    = 1'b1;
            mem_waddr = j_reg[ADDR_W-1:0];
            mem_wdata = vi_reg;
        end
        else
        begin
            mem_we = 1'b0;
        end
    end

    // store read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_I:    mem_raddr = i_reg[ADDR_W-1:0];
            RD_J:    mem_raddr = j_reg[ADDR_W-1:0];
            RD_K:    mem_raddr = k_reg[ADDR_W-1:0];
            default: mem_raddr = i_reg[ADDR_W-1:0];
        endcase
    end

    rpe_ram #(
        .WIDTH (VALUE_W),
        .WORDS (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg   <= rd_value;
            out_last_reg    <= sts.k_last;
            out_dropped_reg <= overflow_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_last    = out_last_reg;
    assign out_dropped = out_dropped_reg;

    // status to the controller
    assign sts.i_done   = (i_reg == count_reg);
    assign sts.j_done   = (j_reg == count_reg);
    assign sts.in_range = (rd_value >= lower_reg) && (rd_value <= upper_reg);
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.k_last   = ((k_reg + CNT_W'(1)) == count_reg);

endmodule

### sv/range_partition_engine.sv
// range_partition_engine: top level, joins controller and datapath to the channels
// depends on rpe_pkg, rpe_if, rpe_ctrl and rpe_dp
//
// Usage:
//   items   : signed 32-bit values, one per item, appended to a 64-entry store.
//             Values arriving when the store is full are dropped and remembered.
//             item_last closes the set and starts the partition.
//   results : after a set closes, every stored value in store order, values in
//             [lower_bound, upper_bound] first; out_last on the final one,
//             out_dropped on all of them if the set lost any value.
//   cfg     : index 0 writes lower_bound, index 1 upper_bound; always ready.
// Operation:
//   a non-last item is taken whenever idle. For a set, the partition reads
//   one store entry at a time through the single read port, in a read and a
//   check state per position and per element scanned in a search, plus a
//   swap state; the scan ends early once a search finds nothing in range.
//   Emission reads one result per free output slot, then the block takes
//   items again while the final result may still wait in the output register.
// Reset clears bounds, fill count and drop flag; the store itself is not cleared.
// A stalled receiver holds the output register and pauses emission.
module range_partition_engine import rpe_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    rpe_item_if.sink   items,
    rpe_result_if.source results,
    rpe_cfg_if.sink    cfg
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;
    logic      item_ready;

    assign items.ready = item_ready;
    assign cfg.ready   = 1'b1;

    rpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (items.valid),
        .item_last  (items.item_last),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    rpe_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .item_value  (items.item_value),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_ready   (results.ready),
        .out_valid   (results.valid),
        .out_value   (results.out_value),
        .out_last    (results.out_last),
        .out_dropped (results.out_dropped)
    );

    // a result is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !results.valid)
        else $error("output register overwritten");

    // the second half of a swap always follows the first
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_SWAP_J) |-> $past(cmd.wr_sel == WR_SWAP_I))
        else $error("swap write to j without write to i");

    // closing a set leaves its last-marked result in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_set |=> results.valid && results.out_last)
        else $error("set closed without a last result");

    // no item is taken while a set is partitioned or emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel != WR_NONE || cmd.load_out) |-> !items.ready)
        else $error("item accepted during partition or emission");

endmodule
